// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the framebuffer draw core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define FBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define FBD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- rtl/core/fbd_pkg.sv -----
// Types, codes and constants of the page framebuffer draw core.
`timescale 1ns / 1ps

package fbd_pkg;

  // Default geometry of the store
  localparam int unsigned MaxColumnsDef = 128;
  localparam int unsigned MaxRowsDef    = 64;

  // Rows held in one byte of a page
  localparam int unsigned PageRows = 8;

  // Stream payload widths
  localparam int unsigned InTdataW  = 48;
  localparam int unsigned OutTdataW = 16;

  // Configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgDisplayWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgDisplayHeight = 1'b1;

  // Request codes
  typedef enum logic [2:0] {
    REQ_PIXEL  = 3'd0,
    REQ_TOGGLE = 3'd1,
    REQ_FILL   = 3'd2,
    REQ_LINE   = 3'd3,
    REQ_CLEAR  = 3'd4,
    REQ_READ   = 3'd5
  } req_e;

  // Byte update modes
  typedef enum logic [1:0] {
    MODE_CLR = 2'd0,
    MODE_SET = 2'd1,
    MODE_TOG = 2'd2
  } mode_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_READ,
    ST_WRITE,
    ST_FETCH,
    ST_FINISH
  } state_e;

  // Control handed to the byte update unit
  typedef struct packed {
    mode_e      mode;
    logic [2:0] lo_bit;  // first row bit touched in the byte
    logic [3:0] hi_bit;  // one past the last row bit touched
  } rmw_ctl_t;

endpackage

// ----- rtl/core/fbd_rmw.sv -----
// Byte read-modify-write unit: builds the row mask and applies set, clear or toggle.
`timescale 1ns / 1ps

module fbd_rmw (
  input  fbd_pkg::rmw_ctl_t ctl_i,
  input  logic [7:0]        old_i,
  output logic [7:0]        new_o,
  output logic [7:0]        mask_o
);

  logic [7:0] mask;

  // Mark the rows of this byte inside [lo_bit, hi_bit)
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      mask[b] = (4'(b) >= {1'b0, ctl_i.lo_bit}) && (4'(b) < ctl_i.hi_bit);
    end
  end

  // Apply the update mode
  always_comb begin
    unique case (ctl_i.mode)
      fbd_pkg::MODE_SET: new_o = old_i | mask;
      fbd_pkg::MODE_TOG: new_o = old_i ^ mask;
      fbd_pkg::MODE_CLR: new_o = old_i & ~mask;
      default:           new_o = old_i;
    endcase
  end

  assign mask_o = mask;

endmodule

// ----- rtl/core/page_mono_framebuffer_draw_core.sv -----
// Top level of the page framebuffer draw core: sequencer, store and stream ports.
// Steps: setup; read and write per byte (pixel, toggle, line, fill) or fetch (read byte),
// then finish. Clear all: setup, then one store byte per cycle, then finish.
// Items: one at a time, the next one taken once its result is loaded and the core is idle.
// Reset: async active low; a clearing pass writes zero to every store byte and
// zeros the store before the first item is taken (config writes accepted meanwhile).
`timescale 1ns / 1ps
`include "assert_macros.svh"

module page_mono_framebuffer_draw_core #(
  parameter int unsigned MAX_COLUMNS = fbd_pkg::MaxColumnsDef,
  parameter int unsigned MAX_ROWS    = fbd_pkg::MaxRowsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // req_type[2:0] x[10:3] y[17:11] rect_w[25:18] rect_h[32:26] on[33] byte_addr[43:34]
  input  logic [fbd_pkg::InTdataW-1:0]   s_axis_tdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // read_data[7:0] status[8]
  output logic [fbd_pkg::OutTdataW-1:0]  m_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fbd_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [fbd_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned Pages      = (MAX_ROWS + fbd_pkg::PageRows - 1) / fbd_pkg::PageRows;
  localparam int unsigned StoreBytes = MAX_COLUMNS * Pages;
  localparam int unsigned AW         = $clog2(StoreBytes);

  // Store
  logic [7:0]    mem [StoreBytes];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata_q;

  // Configuration
  logic [7:0] disp_w_q;
  logic [6:0] disp_h_q;
  logic [8:0] w_eff;
  logic [7:0] h_eff;

  // Sequencer
  fbd_pkg::state_e state_q, state_d;
  logic [2:0]    req_q;
  logic [7:0]    x_q;
  logic [6:0]    y_q;
  logic [7:0]    rw_q;
  logic [6:0]    rh_q;
  logic          on_q;
  logic [9:0]    addr_q;
  logic [7:0]    col_q, col_d;
  logic [8:0]    xe_q, xe_d;
  logic [7:0]    ye_q, ye_d;
  logic [7:0]    row_q, row_d;
  logic [AW-1:0] pbase_q, pbase_d;
  fbd_pkg::mode_e mode_q, mode_d;
  logic          st_q, st_d;
  logic          rdsel_q, rdsel_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          clr_req_q, clr_req_d;

  // Output register
  logic       m_valid_q, m_valid_d;
  logic [7:0] out_rd_q, out_rd_d;
  logic       out_st_q, out_st_d;

  // Datapath helpers
  logic [8:0]  x_sum;
  logic [7:0]  y_sum;
  logic        off_scr;
  logic [12:0] pbase_mul;
  logic [7:0]  pg_start;
  logic [7:0]  pg_end;
  logic [7:0]  row_hi;
  logic [7:0]  hi_span;
  fbd_pkg::rmw_ctl_t rmw_ctl;
  logic [7:0]  rmw_new;
  logic [7:0]  rmw_mask;
  logic        accept;

  // Configuration registers; writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_w_q <= 8'd128;
      disp_h_q <= 7'd64;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fbd_pkg::CfgDisplayWidth:  disp_w_q <= cfg_data_i;
        fbd_pkg::CfgDisplayHeight: disp_h_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Clamp the visible size to the store geometry
  assign w_eff = ({1'b0, disp_w_q} > 9'(MAX_COLUMNS)) ? 9'(MAX_COLUMNS) : {1'b0, disp_w_q};
  assign h_eff = ({1'b0, disp_h_q} > 8'(MAX_ROWS))    ? 8'(MAX_ROWS)    : {1'b0, disp_h_q};

  // Clip sums, wide enough not to wrap
  assign x_sum     = {1'b0, x_q} + {1'b0, rw_q};
  assign y_sum     = {1'b0, y_q} + {1'b0, rh_q};
  assign off_scr   = ({1'b0, x_q} >= w_eff) || ({1'b0, y_q} >= h_eff);
  assign pbase_mul = {9'd0, y_q[6:3]} * {4'd0, w_eff};

  // Row window of the current page
  assign pg_start = {row_q[7:3], 3'b000};
  assign pg_end   = pg_start + 8'(fbd_pkg::PageRows);
  assign row_hi   = (ye_q < pg_end) ? ye_q : pg_end;
  assign hi_span  = row_hi - pg_start;

  assign rmw_ctl.mode   = mode_q;
  assign rmw_ctl.lo_bit = row_q[2:0];
  assign rmw_ctl.hi_bit = hi_span[3:0];

  fbd_rmw u_rmw (
    .ctl_i  (rmw_ctl),
    .old_i  (mem_rdata_q),
    .new_o  (rmw_new),
    .mask_o (rmw_mask)
  );

  assign s_axis_tready = (state_q == fbd_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Next state, store access and output loading
  always_comb begin
    state_d   = state_q;
    col_d     = col_q;
    xe_d      = xe_q;
    ye_d      = ye_q;
    row_d     = row_q;
    pbase_d   = pbase_q;
    mode_d    = mode_q;
    st_d      = st_q;
    rdsel_d   = rdsel_q;
    clr_d     = clr_q;
    clr_req_d = clr_req_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    out_rd_d  = out_rd_q;
    out_st_d  = out_st_q;
    mem_we    = 1'b0;
    mem_waddr = pbase_q + AW'(col_q);
    mem_wdata = rmw_new;
    mem_re    = 1'b0;
    mem_raddr = pbase_q + AW'(col_q);

    unique case (state_q)
      fbd_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = 8'd0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(StoreBytes - 1)) begin
          clr_d   = '0;
          state_d = clr_req_q ? fbd_pkg::ST_FINISH : fbd_pkg::ST_IDLE;
        end
      end

      fbd_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = fbd_pkg::ST_SETUP;
        end
      end

      fbd_pkg::ST_SETUP: begin
        st_d      = 1'b0;
        rdsel_d   = 1'b0;
        clr_req_d = 1'b0;
        col_d     = x_q;
        row_d     = {1'b0, y_q};
        pbase_d   = AW'(pbase_mul);
        xe_d      = (x_sum < w_eff) ? x_sum : w_eff;
        ye_d      = (y_sum < h_eff) ? y_sum : h_eff;
        mode_d    = on_q ? fbd_pkg::MODE_SET : fbd_pkg::MODE_CLR;
        state_d   = fbd_pkg::ST_FINISH;
        unique case (req_q)
          fbd_pkg::REQ_PIXEL, fbd_pkg::REQ_TOGGLE: begin
            xe_d = {1'b0, x_q} + 9'd1;
            ye_d = {1'b0, y_q} + 8'd1;
            if (req_q == fbd_pkg::REQ_TOGGLE) begin
              mode_d = fbd_pkg::MODE_TOG;
            end
            if (off_scr) begin
              st_d = 1'b1;
            end else begin
              state_d = fbd_pkg::ST_READ;
            end
          end
          fbd_pkg::REQ_FILL: begin
            if (off_scr) begin
              st_d = 1'b1;
            end else if (rw_q != 8'd0 && rh_q != 7'd0) begin
              state_d = fbd_pkg::ST_READ;
            end
          end
          fbd_pkg::REQ_LINE: begin
            ye_d = {1'b0, y_q} + 8'd1;
            if (off_scr) begin
              st_d = 1'b1;
            end else if (rw_q != 8'd0) begin
              state_d = fbd_pkg::ST_READ;
            end
          end
          fbd_pkg::REQ_CLEAR: begin
            clr_req_d = 1'b1;
            state_d   = fbd_pkg::ST_CLEAR;
          end
          fbd_pkg::REQ_READ: begin
            state_d = fbd_pkg::ST_FETCH;
          end
          default: ;
        endcase
      end

      fbd_pkg::ST_READ: begin
        mem_re  = 1'b1;
        state_d = fbd_pkg::ST_WRITE;
      end

      fbd_pkg::ST_WRITE: begin
        mem_we = 1'b1;
        // Advance column, then page, then finish
        if (({1'b0, col_q} + 9'd1) < xe_q) begin
          col_d   = col_q + 8'd1;
          state_d = fbd_pkg::ST_READ;
        end else if (pg_end < ye_q) begin
          col_d   = x_q;
          row_d   = pg_end;
          pbase_d = pbase_q + AW'(w_eff);
          state_d = fbd_pkg::ST_READ;
        end else begin
          state_d = fbd_pkg::ST_FINISH;
        end
      end

      fbd_pkg::ST_FETCH: begin
        mem_raddr = AW'(addr_q);
        if (32'(addr_q) < StoreBytes) begin
          mem_re  = 1'b1;
          rdsel_d = 1'b1;
        end else begin
          st_d = 1'b1;
        end
        state_d = fbd_pkg::ST_FINISH;
      end

      fbd_pkg::ST_FINISH: begin
        // Hold until the output register is free
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          out_rd_d  = rdsel_q ? mem_rdata_q : 8'd0;
          out_st_d  = st_q;
          state_d   = fbd_pkg::ST_IDLE;
        end
      end

      default: state_d = fbd_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fbd_pkg::ST_CLEAR;
      clr_q     <= '0;
      clr_req_q <= 1'b0;
      m_valid_q <= 1'b0;
      rdsel_q   <= 1'b0;
      st_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      clr_req_q <= clr_req_d;
      m_valid_q <= m_valid_d;
      rdsel_q   <= rdsel_d;
      st_q      <= st_d;
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= s_axis_tdata[2:0];
      x_q    <= s_axis_tdata[10:3];
      y_q    <= s_axis_tdata[17:11];
      rw_q   <= s_axis_tdata[25:18];
      rh_q   <= s_axis_tdata[32:26];
      on_q   <= s_axis_tdata[33];
      addr_q <= s_axis_tdata[43:34];
    end
    col_q    <= col_d;
    xe_q     <= xe_d;
    ye_q     <= ye_d;
    row_q    <= row_d;
    pbase_q  <= pbase_d;
    mode_q   <= mode_d;
    out_rd_q <= out_rd_d;
    out_st_q <= out_st_d;
  end

  // Store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'd0, out_st_q, out_rd_q};

  // Checks
  `FBD_ASSERT(a_we_state,
              mem_we |-> (state_q == fbd_pkg::ST_CLEAR || state_q == fbd_pkg::ST_WRITE),
              "store written outside clear or write step")
  `FBD_ASSERT(a_waddr_range,
              (state_q == fbd_pkg::ST_WRITE) |-> (32'(mem_waddr) < StoreBytes),
              "pixel write beyond the store")
  `FBD_ASSERT(a_mask_nonzero,
              (state_q == fbd_pkg::ST_WRITE) |-> (rmw_mask != 8'd0),
              "byte update touches no row")
  `FBD_ASSERT(a_accept_setup,
              accept |=> (state_q == fbd_pkg::ST_SETUP),
              "accepted item did not enter setup")

endmodule
